// File: rtl/core/pfse_pkg.sv
// ----------------------------------------------------------------------------
// pfse_pkg
// Types and constants shared by the prefixed field span extractor.
// ----------------------------------------------------------------------------
package pfse_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_HI  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PREFIX_LEN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FIELD_CNT  = 3'd4;

  // prefix storage is fixed by the two 64-bit registers
  localparam int unsigned PREFIX_BYTES = 16;
  localparam int unsigned LEN_W        = 5;

  // reset values of the registers
  localparam logic [LEN_W-1:0] PREFIX_LEN_RST = 5'd15;
  localparam logic [7:0]       SEPARATOR_RST  = 8'd44;
  localparam logic [7:0]       FIELD_CNT_RST  = 8'd6;

  // result status codes
  localparam logic [1:0] ST_BYTE     = 2'd0;
  localparam logic [1:0] ST_COMPLETE = 2'd1;
  localparam logic [1:0] ST_ERROR    = 2'd2;

  typedef logic [PREFIX_BYTES-1:0][7:0] prefix_t;

  typedef enum logic [1:0] {
    PH_SEARCH = 2'd0,
    PH_DROP   = 2'd1,
    PH_EMIT   = 2'd2,
    PH_DONE   = 2'd3
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;
  } out_t;

  // result write strobes toward the output queue
  typedef struct packed {
    logic push_a;
    logic push_b;
  } push_t;

endpackage

// File: rtl/core/pfse_cell.sv
// ----------------------------------------------------------------------------
// pfse_cell
// One byte of the sliding window: holds a byte, takes its neighbor's byte on
// a shift and compares the incoming byte against its prefix byte.
// ----------------------------------------------------------------------------
module pfse_cell #(
  parameter int unsigned POS        = 0,
  parameter int unsigned PREFIX_MAX = 16
) (
  input  logic                         clk_i,
  input  logic                         shift_i,
  input  logic [7:0]                   byte_i,
  input  logic [pfse_pkg::LEN_W-1:0]   len_i,
  input  pfse_pkg::prefix_t            prefix_i,
  output logic [7:0]                   byte_o,
  output logic                         ok_o
);
  import pfse_pkg::*;

  localparam int unsigned SUM_W = LEN_W + 1;

  logic [7:0]       byte_q;
  logic [7:0]       byte_d;
  logic [SUM_W-1:0] sum;
  logic             in_span;
  logic [3:0]       pidx;

  // prefix byte that lines up with this cell for the current length
  assign sum     = SUM_W'(POS) + SUM_W'(len_i);
  assign in_span = (sum >= SUM_W'(PREFIX_MAX));
  assign pidx    = 4'(sum - SUM_W'(PREFIX_MAX));

  // compare the byte that lands here on this shift
  assign ok_o = !in_span || (byte_i == prefix_i[pidx]);

  // window byte
  assign byte_d = shift_i ? byte_i : byte_q;

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;

endmodule

// File: rtl/core/pfse_out_fifo.sv
// ----------------------------------------------------------------------------
// pfse_out_fifo
// Four-entry result queue that takes up to two beats a cycle and hands out
// one beat a cycle.
// ----------------------------------------------------------------------------
module pfse_out_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pfse_pkg::push_t push_i,
  input  pfse_pkg::out_t  data_a_i,
  input  pfse_pkg::out_t  data_b_i,
  output logic            space_o,
  output logic            valid_o,
  input  logic            ready_i,
  output pfse_pkg::out_t  data_o
);
  import pfse_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  out_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             pop;
  logic [PTR_W-1:0] wr_ptr_b;

  assign pop      = valid_o && ready_i;
  assign wr_ptr_b = wr_ptr_q + PTR_W'(1);

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push_i.push_a) + PTR_W'(push_i.push_b);
    rd_ptr_d = rd_ptr_q + PTR_W'(pop);
    count_d  = count_q + CNT_W'(push_i.push_a) + CNT_W'(push_i.push_b) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i.push_a) begin
      mem_q[wr_ptr_q] <= data_a_i;
    end
    if (push_i.push_b) begin
      mem_q[wr_ptr_b] <= data_b_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign space_o = (count_q <= CNT_W'(DEPTH - 2));

  // checks
  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.push_a |-> (count_q <= CNT_W'(DEPTH - 2)))
    else $error("result queue written without room for two beats");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("result queue count beyond depth");

  a_count_track : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!push_i.push_a && pop) |=> (count_q == $past(count_q) - CNT_W'(1)))
    else $error("result queue count lost a pop");

endmodule

// File: rtl/core/prefixed_field_span_extractor.sv
// ----------------------------------------------------------------------------
// prefixed_field_span_extractor
// Finds a configured prefix in a byte frame and streams out the field span
// that follows it.
// ----------------------------------------------------------------------------
// The block takes one frame byte per cycle while it is ready. In the search
// phase each byte shifts into a row of PREFIX_MAX window cells, each
// comparing its byte against the matching prefix byte. After a match the next
// byte is dropped, then bytes other than separators go out with status 0 up
// to the field_count-th separator, which becomes a completion beat
// (status 1). A frame that ends before completion, that has no match, or
// that runs with field_count zero ends in an error beat (status 2); span bytes
// already sent must then be discarded. Results pass through a four-entry
// queue: the input is ready while the queue holds at most two beats, so a
// steady stream runs at one byte per cycle while the receiver keeps up; a
// byte that yields a span byte and the error beat pushes both. Configuration
// writes take effect at the next byte and belong between frames.
// ----------------------------------------------------------------------------
module prefixed_field_span_extractor #(
  parameter int unsigned PREFIX_MAX = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  pfse_pkg::in_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output pfse_pkg::out_t                    out_data_o,
  input  logic                              cfg_we_i,
  input  logic [pfse_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pfse_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);
  import pfse_pkg::*;

  localparam int unsigned FILL_W = $clog2(PREFIX_MAX + 1);

  // configuration registers
  logic [63:0]      prefix_lo_q;
  logic [63:0]      prefix_hi_q;
  logic [LEN_W-1:0] prefix_len_q;
  logic [7:0]       separator_q;
  logic [7:0]       field_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prefix_lo_q  <= '0;
      prefix_hi_q  <= '0;
      prefix_len_q <= PREFIX_LEN_RST;
      separator_q  <= SEPARATOR_RST;
      field_cnt_q  <= FIELD_CNT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PREFIX_LO:  prefix_lo_q  <= cfg_wdata_i;
        CFG_PREFIX_HI:  prefix_hi_q  <= cfg_wdata_i;
        CFG_PREFIX_LEN: prefix_len_q <= cfg_wdata_i[LEN_W-1:0];
        CFG_SEPARATOR:  separator_q  <= cfg_wdata_i[7:0];
        CFG_FIELD_CNT:  field_cnt_q  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  prefix_t          prefix;
  logic [LEN_W-1:0] len_eff;

  assign prefix  = {prefix_hi_q, prefix_lo_q};
  assign len_eff = (prefix_len_q > LEN_W'(PREFIX_MAX)) ? LEN_W'(PREFIX_MAX) : prefix_len_q;

  // control state
  phase_e            phase_q, phase_d, phase_cur;
  logic [FILL_W-1:0] fill_q, fill_d, fill_inc;
  logic [7:0]        seen_q, seen_d, seen_inc;

  logic in_acc;
  logic shift;
  logic match;
  push_t push;
  out_t  res_a, res_b;
  logic  fifo_space;

  assign in_acc     = in_valid_i && in_ready_o;
  assign in_ready_o = fifo_space;

  // an empty prefix counts as matched before the first byte
  assign phase_cur = (phase_q == PH_SEARCH && len_eff == '0) ? PH_DROP : phase_q;
  assign shift     = in_acc && (phase_cur == PH_SEARCH);

  // window cell row, newest byte at the top cell
  logic [PREFIX_MAX-1:0][7:0] cell_byte;
  logic [PREFIX_MAX-1:0]      cell_ok;

  for (genvar j = 0; j < PREFIX_MAX; j++) begin : g_cell
    logic [7:0] feed;
    if (j == PREFIX_MAX - 1) begin : g_top
      assign feed = in_data_i.data_byte;
    end else begin : g_mid
      assign feed = cell_byte[j+1];
    end
    pfse_cell #(
      .POS        (j),
      .PREFIX_MAX (PREFIX_MAX)
    ) u_cell (
      .clk_i    (clk_i),
      .shift_i  (shift),
      .byte_i   (feed),
      .len_i    (len_eff),
      .prefix_i (prefix),
      .byte_o   (cell_byte[j]),
      .ok_o     (cell_ok[j])
    );
  end

  assign fill_inc = (fill_q == FILL_W'(PREFIX_MAX)) ? fill_q : fill_q + FILL_W'(1);
  assign seen_inc = (seen_q == 8'hFF) ? seen_q : seen_q + 8'd1;
  assign match    = (LEN_W'(fill_inc) >= len_eff) && (&cell_ok);

  // next state and result beats
  always_comb begin
    phase_d = phase_q;
    fill_d  = fill_q;
    seen_d  = seen_q;
    push    = '0;
    res_a   = '0;
    res_b   = '0;
    if (in_acc) begin
      phase_d = phase_cur;
      case (phase_cur)
        PH_SEARCH: begin
          fill_d = fill_inc;
          if (match) begin
            phase_d = PH_DROP;
          end
        end
        PH_DROP: begin
          if (field_cnt_q != '0) begin
            phase_d = PH_EMIT;
          end
        end
        PH_EMIT: begin
          if (in_data_i.data_byte == separator_q) begin
            seen_d = seen_inc;
            if (seen_inc >= field_cnt_q) begin
              push.push_a = 1'b1;
              res_a       = '{out_byte: 8'd0, status: ST_COMPLETE, last: 1'b1};
              phase_d     = PH_DONE;
            end
          end else begin
            push.push_a = 1'b1;
            res_a       = '{out_byte: in_data_i.data_byte, status: ST_BYTE, last: 1'b0};
          end
        end
        default: ;
      endcase
      // frame end: error beat unless complete, then back to search
      if (in_data_i.frame_end) begin
        if (phase_d != PH_DONE) begin
          if (push.push_a) begin
            push.push_b = 1'b1;
            res_b       = '{out_byte: 8'd0, status: ST_ERROR, last: 1'b1};
          end else begin
            push.push_a = 1'b1;
            res_a       = '{out_byte: 8'd0, status: ST_ERROR, last: 1'b1};
          end
        end
        phase_d = PH_SEARCH;
        fill_d  = '0;
        seen_d  = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEARCH;
      fill_q  <= '0;
      seen_q  <= '0;
    end else begin
      phase_q <= phase_d;
      fill_q  <= fill_d;
      seen_q  <= seen_d;
    end
  end

  // result queue
  pfse_out_fifo u_out_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_a_i (res_a),
    .data_b_i (res_b),
    .space_o  (fifo_space),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .data_o   (out_data_o)
  );

  // checks
  a_frame_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.frame_end) |=>
      (phase_q == PH_SEARCH && fill_q == '0 && seen_q == '0))
    else $error("state not cleared after frame end");

  a_push_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.push_b |-> (push.push_a && res_a.status == ST_BYTE && res_b.status == ST_ERROR))
    else $error("second beat of a byte is not span byte then error");

  a_done_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && phase_q == PH_DONE && !in_data_i.frame_end) |-> !push.push_a)
    else $error("result beat after span completion");

endmodule

// File: tb/span_checker.sv
// ----------------------------------------------------------------------------
// span_checker
// Watches the byte, result and register ports of the prefixed field span
// extractor. It keeps its own copy of the registers and the search state,
// works out the result beats that each accepted byte causes, and compares
// every accepted result beat with the oldest beat still due.
// ----------------------------------------------------------------------------
module span_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  pfse_pkg::in_t                   in_data_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  pfse_pkg::out_t                  out_data_i,
  input  logic                            cfg_we_i,
  input  logic [pfse_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [pfse_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int unsigned                     mismatch_count_o,
  output int unsigned                     beats_due_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import pfse_pkg::*;

  // register copies
  logic [63:0]      pfx_lo;
  logic [63:0]      pfx_hi;
  logic [LEN_W-1:0] pfx_len;
  logic [7:0]       sep_byte;
  logic [7:0]       field_cnt;

  // search state, newest byte at the top of the window
  logic [7:0]       win [PREFIX_BYTES];
  logic [4:0]       fill;
  phase_e           phase_q;
  logic [7:0]       seps_seen;

  out_t             span_beats_due [$];
  out_t             want;
  int unsigned      fails;
  int unsigned      results_seen;

  function automatic logic [7:0] prefix_at(int unsigned k);
    return (k < 8) ? pfx_lo[8*k +: 8] : pfx_hi[8*(k-8) +: 8];
  endfunction

  task automatic clear_frame();
    for (int i = 0; i < PREFIX_BYTES; i++) win[i] = 8'h00;
    fill      = '0;
    phase_q   = PH_SEARCH;
    seps_seen = '0;
  endtask

  task automatic report_bad(input string what, input logic [10:0] got,
                            input logic [10:0] exp_val);
    $display("[%0t] result %0d: %s got %0h exp %0h", $realtime, results_seen,
             what, got, exp_val);
    fails++;
  endtask

  // one accepted byte: advance the search state, queue the beats it causes
  task automatic advance(input in_t beat);
    int unsigned len;
    logic        hit;
    len = (pfx_len > PREFIX_BYTES) ? PREFIX_BYTES : 32'(pfx_len);
    if (phase_q == PH_SEARCH && len == 0) phase_q = PH_DROP;
    case (phase_q)
      PH_SEARCH: begin
        for (int i = 0; i < PREFIX_BYTES - 1; i++) win[i] = win[i+1];
        win[PREFIX_BYTES-1] = beat.data_byte;
        if (fill < PREFIX_BYTES) fill++;
        hit = (32'(fill) >= len);
        for (int k = 0; k < len; k++) begin
          if (win[PREFIX_BYTES-len+k] != prefix_at(k)) hit = 1'b0;
        end
        if (hit) phase_q = PH_DROP;
      end
      PH_DROP: begin
        if (field_cnt != 0) phase_q = PH_EMIT;
      end
      PH_EMIT: begin
        if (beat.data_byte == sep_byte) begin
          if (seps_seen < 8'd255) seps_seen++;
          if (seps_seen >= field_cnt) begin
            span_beats_due.push_back(
              out_t'{out_byte: 8'h00, status: ST_COMPLETE, last: 1'b1});
            phase_q = PH_DONE;
          end
        end else begin
          span_beats_due.push_back(
            out_t'{out_byte: beat.data_byte, status: ST_BYTE, last: 1'b0});
        end
      end
      default: ;
    endcase
    // frame end: error unless the span completed, then back to search
    if (beat.frame_end) begin
      if (phase_q != PH_DONE) begin
        span_beats_due.push_back(
          out_t'{out_byte: 8'h00, status: ST_ERROR, last: 1'b1});
      end
      clear_frame();
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pfx_lo       = '0;
      pfx_hi       = '0;
      pfx_len      = PREFIX_LEN_RST;
      sep_byte     = SEPARATOR_RST;
      field_cnt    = FIELD_CNT_RST;
      clear_frame();
      span_beats_due.delete();
      fails        = 0;
      results_seen = 0;
      mismatch_count_o <= 0;
      beats_due_o      <= 0;
    end else begin
      // byte beat in
      if (in_valid_i && in_ready_i) advance(in_data_i);

      // result beat out
      if (out_valid_i && out_ready_i) begin
        if (span_beats_due.size() == 0) begin
          report_bad("beat with nothing due", out_data_i, '0);
        end else begin
          want = span_beats_due.pop_front();
          if (out_data_i.out_byte != want.out_byte)
            report_bad("out_byte", 11'(out_data_i.out_byte), 11'(want.out_byte));
          if (out_data_i.status != want.status)
            report_bad("status", 11'(out_data_i.status), 11'(want.status));
          if (out_data_i.last != want.last)
            report_bad("last", 11'(out_data_i.last), 11'(want.last));
        end
        results_seen++;
      end

      // register writes take effect from the next byte
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_PREFIX_LO:  pfx_lo    = cfg_wdata_i;
          CFG_PREFIX_HI:  pfx_hi    = cfg_wdata_i;
          CFG_PREFIX_LEN: pfx_len   = cfg_wdata_i[LEN_W-1:0];
          CFG_SEPARATOR:  sep_byte  = cfg_wdata_i[7:0];
          CFG_FIELD_CNT:  field_cnt = cfg_wdata_i[7:0];
          default: ;
        endcase
      end

      mismatch_count_o <= fails;
      beats_due_o      <= span_beats_due.size();
    end
  end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus for the prefixed field span extractor: a few hand-built frames
// that hit the corner cases, then random frames under several register
// settings and idle patterns. Results are judged by span_checker.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pfse_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 24;
  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned PHASE_BYTES  = 64;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int unsigned           mismatch_count;
  int unsigned           beats_due;

  // register values as last written, for building frames
  logic [63:0]           cur_lo;
  logic [63:0]           cur_hi;
  logic [LEN_W-1:0]      cur_len;
  logic [7:0]            cur_sep;
  logic [7:0]            cur_fc;

  int unsigned           snd_idle  = 0;
  int unsigned           rcv_stall = 0;
  int unsigned           items_sent = 0;
  int unsigned           cycle_count = 0;
  in_t                   frame_q [$];

  prefixed_field_span_extractor u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  span_checker u_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_data_i        (in_data),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_data_i       (out_data),
    .cfg_we_i         (cfg_we),
    .cfg_idx_i        (cfg_idx),
    .cfg_wdata_i      (cfg_wdata),
    .mismatch_count_o (mismatch_count),
    .beats_due_o      (beats_due)
  );

  // clock
  initial begin
    forever #6 clk = ~clk;
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rcv_stall);
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] prefix_byte_at(int unsigned k);
    return (k < 8) ? cur_lo[8*k +: 8] : cur_hi[8*(k-8) +: 8];
  endfunction

  // random byte that is never the separator
  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    if (b == cur_sep) b ^= 8'h01;
    return b;
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++)
      frame_q.push_back(in_t'{data_byte: s[i], frame_end: 1'b0});
  endtask

  // one byte beat, with random sender gaps ahead of it
  task automatic send_beat(input in_t beat);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // send the queued frame, frame_end on its last beat
  task automatic send_frame();
    in_t beat;
    for (int i = 0; i < frame_q.size(); i++) begin
      beat = frame_q[i];
      beat.frame_end = (i == frame_q.size() - 1);
      send_beat(beat);
    end
    frame_q.delete();
  endtask

  // wait until every due result has arrived and the block has gone quiet
  task automatic settle();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
      while (beats_due != 0) @(posedge clk);
      repeat (DRAIN_CYCLES) @(posedge clk);
    end while (beats_due != 0);
  endtask

  // write all five registers, one per cycle
  task automatic configure(input logic [63:0] lo, input logic [63:0] hi,
                           input logic [LEN_W-1:0] len, input logic [7:0] sepv,
                           input logic [7:0] fc);
    logic [CFG_DATA_W-1:0] vals [5];
    logic [CFG_IDX_W-1:0]  idxs [5];
    cur_lo  = lo;
    cur_hi  = hi;
    cur_len = len;
    cur_sep = sepv;
    cur_fc  = fc;
    vals = '{lo, hi, 64'(len), 64'(sepv), 64'(fc)};
    idxs = '{CFG_PREFIX_LO, CFG_PREFIX_HI, CFG_PREFIX_LEN, CFG_SEPARATOR,
             CFG_FIELD_CNT};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idxs[i];
      cfg_wdata <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [63:0]      lo;
    logic [63:0]      hi;
    logic [LEN_W-1:0] len;
    logic [7:0]       sepv;
    logic [7:0]       fc;
    int unsigned      eff_len;
    int unsigned      start;
    int unsigned      target;
    int unsigned      cut;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: prefix "$AB", comma, two fields, trailing byte ignored
    configure(64'h0000_0000_0042_4124, 64'h0, 5'd3, 8'd44, 8'd2);
    push_text("x$AB_a,b,c");
    send_frame();
    // frame ends inside the span: byte then error
    push_text("$AB_");
    frame_q.push_back(in_t'{data_byte: 8'hFF, frame_end: 1'b0});
    send_frame();
    // no match at all
    frame_q.push_back(in_t'{data_byte: 8'h00, frame_end: 1'b0});
    send_frame();
    // dropped byte is a separator, frame ends on the completing separator
    settle();
    configure(64'h0000_0000_0042_4124, 64'h0, 5'd3, 8'd44, 8'd1);
    push_text("$AB,,");
    send_frame();
    // zero-length prefix with zero fields
    settle();
    configure(64'h0000_0000_0042_4124, 64'h0, 5'd0, 8'd44, 8'd0);
    push_text("ab");
    send_frame();

    // random phases
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph % 4)
        0:       begin snd_idle = 0;  rcv_stall = 0;  end
        1:       begin snd_idle = 80; rcv_stall = 0;  end
        2:       begin snd_idle = 0;  rcv_stall = 80; end
        default: begin snd_idle = 16; rcv_stall = 16; end
      endcase
      lo   = {$urandom, $urandom};
      hi   = {$urandom, $urandom};
      len  = LEN_W'($urandom_range(1, 20));
      sepv = 8'($urandom_range(255));
      fc   = 8'($urandom_range(1, 4));
      case (ph)
        0:       begin lo = '1; hi = '1; len = 5'd1; sepv = 8'd44; end
        1:       begin lo = '0; hi = '0; len = 5'd16; sepv = 8'd0; end
        2:       begin len = 5'd31; sepv = 8'd255; end
        3:       begin len = 5'd0; fc = 8'd255; end
        4:       begin len = 5'd2; fc = 8'd0; end
        5:       fc = 8'd1;
        default: ;
      endcase
      configure(lo, hi, len, sepv, fc);
      eff_len = (cur_len > PREFIX_BYTES) ? PREFIX_BYTES : 32'(cur_len);
      start = items_sent;

      while (items_sent - start < PHASE_BYTES) begin
        if ($urandom_range(99) < 75) begin
          // well-formed: lead-in, prefix, dropped byte, fields, tail
          repeat ($urandom_range(0, 3))
            frame_q.push_back(in_t'{data_byte: 8'($urandom_range(255)),
                                    frame_end: 1'b0});
          for (int k = 0; k < eff_len; k++)
            frame_q.push_back(in_t'{data_byte: prefix_byte_at(k), frame_end: 1'b0});
          frame_q.push_back(in_t'{
            data_byte: ($urandom_range(3) == 0) ? cur_sep : 8'($urandom_range(255)),
            frame_end: 1'b0});
          if (cur_fc == 0)
            target = $urandom_range(0, 2);
          else if (cur_fc <= 5 && $urandom_range(99) < 70)
            target = 32'(cur_fc);
          else
            target = $urandom_range(0, (cur_fc > 5) ? 5 : 32'(cur_fc) - 1);
          for (int f = 0; f < target; f++) begin
            repeat ($urandom_range(0, 3))
              frame_q.push_back(in_t'{data_byte: plain_byte(), frame_end: 1'b0});
            frame_q.push_back(in_t'{data_byte: cur_sep, frame_end: 1'b0});
          end
          repeat ($urandom_range(0, 3))
            frame_q.push_back(in_t'{data_byte: 8'($urandom_range(255)),
                                    frame_end: 1'b0});
          // sometimes cut the frame short
          if ($urandom_range(9) == 0) begin
            cut = $urandom_range(0, frame_q.size() / 2);
            repeat (cut) void'(frame_q.pop_back());
          end
        end else begin
          // noise frame
          repeat ($urandom_range(1, 10))
            frame_q.push_back(in_t'{
              data_byte: ($urandom_range(3) == 0) ? cur_sep : 8'($urandom_range(255)),
              frame_end: 1'b0});
        end
        send_frame();
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
